[hdl/scd_pkg.sv]
// shared types and constants of the sketch command stream decoder
package scd_pkg;

	localparam int unsigned COORD_W = 32;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

	// command opcodes
	localparam logic [4:0] OP_MOVE_X  = 5'd0;
	localparam logic [4:0] OP_MOVE_Y  = 5'd1;
	localparam logic [4:0] OP_WAIT    = 5'd2;
	localparam logic [4:0] OP_PEN     = 5'd3;
	localparam logic [4:0] OP_CLEAR   = 5'd4;
	localparam logic [4:0] OP_KEY     = 5'd5;
	localparam logic [4:0] OP_RED     = 5'd6;
	localparam logic [4:0] OP_GREEN   = 5'd7;
	localparam logic [4:0] OP_BLUE    = 5'd8;
	localparam logic [4:0] OP_OPACITY = 5'd9;

	// short form opcode field value that selects the long form
	localparam logic [1:0] SHORT_LONG_FORM = 2'd3;

	// remembered last command, three bits wide
	localparam logic [2:0] PREV_WAIT = 3'd2;
	localparam logic [2:0] PREV_PEN  = 3'd3;

	// result kinds
	localparam logic [1:0] KIND_LINE  = 2'd0;
	localparam logic [1:0] KIND_PAUSE = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;
	localparam logic [1:0] KIND_KEY   = 2'd3;

	localparam logic [31:0] COLOUR_DEFAULT = 32'hffff_ffff;

	typedef struct packed {
		logic [4:0]  opcode;
		logic [31:0] operand;   // low 32 bits of the operand, sign-extended but for a short-form wait
		logic        neg;       // operand sign
	} cmd_t;

	typedef struct packed {
		logic [1:0]         command_kind;
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
		logic [31:0]        line_colour;
		logic               use_default_colour;
		logic [31:0]        pause_amount;
		logic               last_of_run;
	} res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

[hdl/sketch_command_stream_decoder_top.sv]
// Sketch command stream decoder: takes one drawing-instruction byte per cycle
// and emits line, pause, clear and key-wait commands. The parser accepts a byte
// every cycle while its four-entry command queue has room; the executor retires
// at most one queued command per cycle, and each command delivers at most one
// result per cycle, so a wait that first flushes a pending line holds the
// executor until its pause is sent. A byte that completes a command is written
// into the command queue, and its first result is loaded from the queue head
// into the output register. The input stalls only when the queue fills, either
// behind a stalled output or behind a run of line-flushing waits.
module sketch_command_stream_decoder_top import scd_pkg::*; #(
	parameter int unsigned OPERAND_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  code_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  command_kind,
	output logic signed [31:0] start_x,
	output logic signed [31:0] start_y,
	output logic signed [31:0] end_x,
	output logic signed [31:0] end_y,
	output logic [31:0] line_colour,
	output logic        use_default_colour,
	output logic signed [31:0] pause_amount,
	output logic        last_of_run
);

	logic   accept;
	logic   push;
	cmd_t   push_cmd;
	cmd_t   head;
	qstat_t qstat;
	logic   pop;
	res_t   res;

	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;

	scd_front #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.code_byte(code_byte),
		.push     (push),
		.cmd      (push_cmd)
	);

	scd_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.stat    (qstat)
	);

	scd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (!qstat.empty),
		.q_cmd    (head),
		.q_pop    (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.res      (res)
	);

	assign command_kind       = res.command_kind;
	assign start_x            = $signed(res.start_x);
	assign start_y            = $signed(res.start_y);
	assign end_x              = $signed(res.end_x);
	assign end_y              = $signed(res.end_y);
	assign line_colour        = res.line_colour;
	assign use_default_colour = res.use_default_colour;
	assign pause_amount       = $signed(res.pause_amount);
	assign last_of_run        = res.last_of_run;

endmodule

[hdl/scd_front.sv]
// byte parser: short and long forms, continuation bytes, command push
module scd_front import scd_pkg::*; #(
	parameter int unsigned OPERAND_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] code_byte,
	output logic       push,
	output cmd_t       cmd
);

	localparam int unsigned EXT_W = (OPERAND_WIDTH > 32) ? OPERAND_WIDTH : 32;

	logic                     in_ext_q;
	logic                     first_q;
	logic [4:0]               pend_q;
	logic [OPERAND_WIDTH-1:0] acc_q;

	logic                     in_ext_d;
	logic                     first_d;
	logic [4:0]               pend_d;
	logic [OPERAND_WIDTH-1:0] acc_d;
	logic [OPERAND_WIDTH-1:0] acc_base;
	logic [EXT_W-1:0]         acc_ext;
	logic                     push_c;

	assign acc_base = first_q ? {OPERAND_WIDTH{code_byte[6]}} : acc_q;
	assign acc_ext  = EXT_W'($signed(acc_d));

	always_comb begin
		in_ext_d = in_ext_q;
		first_d  = first_q;
		pend_d   = pend_q;
		acc_d    = acc_q;
		push_c   = 1'b0;
		cmd      = '0;
		if (!in_ext_q) begin
			if (code_byte[7:6] != SHORT_LONG_FORM) begin
				push_c = 1'b1;
				cmd.opcode = {3'b000, code_byte[7:6]};
				// wait takes its operand unsigned, the moves signed
				if ({3'b000, code_byte[7:6]} == OP_WAIT) begin
					cmd.operand = {26'd0, code_byte[5:0]};
				end else begin
					cmd.operand = {{26{code_byte[5]}}, code_byte[5:0]};
					cmd.neg = code_byte[5];
				end
			end else if (!code_byte[5]) begin
				push_c = 1'b1;
				cmd.opcode = code_byte[4:0];
			end else begin
				in_ext_d = 1'b1;
				first_d  = 1'b1;
				pend_d   = code_byte[4:0];
			end
		end else begin
			in_ext_d = code_byte[7];
			first_d  = 1'b0;
			acc_d    = {acc_base[OPERAND_WIDTH-8:0], code_byte[6:0]};
			if (!code_byte[7]) begin
				push_c      = 1'b1;
				cmd.opcode  = pend_q;
				cmd.operand = acc_ext[31:0];
				cmd.neg     = acc_d[OPERAND_WIDTH-1];
			end
		end
	end

	assign push = accept && push_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ext_q <= 1'b0;
			first_q  <= 1'b1;
			pend_q   <= '0;
			acc_q    <= '0;
		end else if (accept) begin
			in_ext_q <= in_ext_d;
			first_q  <= first_d;
			pend_q   <= pend_d;
			acc_q    <= acc_d;
		end
	end

endmodule

[hdl/scd_cmd_queue.sv]
// short command queue between parser and executor
module scd_cmd_queue import scd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  cmd_t   push_cmd,
	input  logic   pop,
	output cmd_t   head,
	output qstat_t stat
);

	cmd_t              mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign stat.full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.full |-> !push || pop)
		else $error("command queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("command queue read while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W+1)'(QUEUE_DEPTH))
		else $error("command queue count out of range");

endmodule

[hdl/scd_back.sv]
// command executor: turtle state, result generation and output register
module scd_back import scd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   q_valid,
	input  cmd_t   q_cmd,
	output logic   q_pop,
	output logic   out_valid,
	input  logic   out_ready,
	output res_t   res
);

	logic [COORD_W-1:0] pen_x_q, pen_y_q, tgt_x_q, tgt_y_q;
	logic               lifted_q;
	logic [2:0]         prev_q;
	logic [31:0]        colour_q;
	logic               phase_q;   // line of a wait already sent
	logic               out_valid_q;
	res_t               res_q;

	logic  prev_quiet;
	logic  wait_line;
	logic  pen_line;
	logic  emit;
	logic  done;
	logic  out_space;
	logic  advance;
	res_t  line_res;
	res_t  emit_res;

	assign prev_quiet = (prev_q == PREV_WAIT) || (prev_q == PREV_PEN);
	assign wait_line  = !prev_quiet;
	assign pen_line   = lifted_q == 1'b0 && !prev_quiet;

	always_comb begin
		line_res = '0;
		line_res.command_kind       = KIND_LINE;
		line_res.start_x            = pen_x_q;
		line_res.start_y            = pen_y_q;
		line_res.end_x              = tgt_x_q;
		line_res.end_y              = tgt_y_q;
		line_res.line_colour        = colour_q;
		line_res.use_default_colour = (colour_q == COLOUR_DEFAULT);
	end

	always_comb begin
		emit     = 1'b0;
		done     = 1'b1;
		emit_res = '0;
		unique case (q_cmd.opcode)
			OP_WAIT: begin
				emit = 1'b1;
				if (wait_line && !phase_q) begin
					emit_res = line_res;
					done     = 1'b0;
				end else begin
					emit_res.command_kind = KIND_PAUSE;
					emit_res.pause_amount = q_cmd.operand;
					emit_res.last_of_run  = 1'b1;
				end
			end
			OP_PEN: begin
				emit = pen_line;
				emit_res = line_res;
				emit_res.last_of_run = 1'b1;
			end
			OP_CLEAR: begin
				emit = 1'b1;
				emit_res.command_kind = KIND_CLEAR;
				emit_res.last_of_run  = 1'b1;
			end
			OP_KEY: begin
				emit = 1'b1;
				emit_res.command_kind = KIND_KEY;
				emit_res.last_of_run  = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign out_space = !out_valid_q || out_ready;
	assign advance   = q_valid && (!emit || out_space);
	assign q_pop     = advance && done;
	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= emit_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
			pen_x_q     <= '0;
			pen_y_q     <= '0;
			tgt_x_q     <= '0;
			tgt_y_q     <= '0;
			lifted_q    <= 1'b1;
			prev_q      <= PREV_PEN;
			colour_q    <= COLOUR_DEFAULT;
		end else begin
			if (advance && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				phase_q <= !done;
			end
			if (q_pop) begin
				unique case (q_cmd.opcode)
					OP_MOVE_X: begin
						tgt_x_q <= tgt_x_q + q_cmd.operand;
						prev_q  <= OP_MOVE_X[2:0];
					end
					OP_MOVE_Y: begin
						tgt_y_q <= tgt_y_q + q_cmd.operand;
						prev_q  <= OP_MOVE_Y[2:0];
					end
					OP_WAIT: begin
						if (wait_line) begin
							pen_x_q <= tgt_x_q;
							pen_y_q <= tgt_y_q;
						end
						prev_q <= PREV_WAIT;
					end
					OP_PEN: begin
						lifted_q <= !lifted_q;
						pen_x_q  <= tgt_x_q;
						pen_y_q  <= tgt_y_q;
						prev_q   <= PREV_PEN;
					end
					OP_CLEAR: begin
						lifted_q <= 1'b1;
						prev_q   <= OP_CLEAR[2:0];
					end
					OP_RED: begin
						if (!q_cmd.neg) colour_q[31:24] <= q_cmd.operand[7:0];
					end
					OP_GREEN: begin
						if (!q_cmd.neg) colour_q[23:16] <= q_cmd.operand[7:0];
					end
					OP_BLUE: begin
						if (!q_cmd.neg) colour_q[15:8] <= q_cmd.operand[7:0];
					end
					OP_OPACITY: begin
						if (!q_cmd.neg) colour_q[7:0] <= q_cmd.operand[7:0];
					end
					default: begin
						prev_q <= prev_q;
					end
				endcase
			end
		end
	end

	a_phase_only_wait: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> q_valid && q_cmd.opcode == OP_WAIT)
		else $error("second half of a wait without a wait at the queue head");

	a_phase_ends_pause: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q && advance |=> out_valid_q && res_q.command_kind == KIND_PAUSE)
		else $error("wait did not finish with a pause");

	a_hold_unread: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(res_q))
		else $error("result register changed before transfer");

endmodule
